/* design/hrt_pkg.sv */
// Shared types, character constants and the per-byte classification functions
// for the HTTP request tokenizer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hrt_pkg;

	// Characters that steer the parse.
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SP    = 8'h20;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;

	// Byte kinds.
	localparam logic [2:0] KIND_DELIM  = 3'd0;
	localparam logic [2:0] KIND_METHOD = 3'd1;
	localparam logic [2:0] KIND_PATH   = 3'd2;
	localparam logic [2:0] KIND_VER    = 3'd3;
	localparam logic [2:0] KIND_HNAME  = 3'd4;
	localparam logic [2:0] KIND_HVALUE = 3'd5;
	localparam logic [2:0] KIND_BODY   = 3'd6;

	// Report codes.
	localparam logic [1:0] METHOD_OTHER = 2'd0;
	localparam logic [1:0] METHOD_GET   = 2'd1;
	localparam logic [1:0] METHOD_POST  = 2'd2;
	localparam logic [1:0] VER_INVALID  = 2'd0;
	localparam logic [1:0] VER_1_0      = 2'd1;
	localparam logic [1:0] VER_1_1      = 2'd2;

	// Length limits.
	localparam logic [2:0] METHOD_LEN_MAX = 3'd7;
	localparam logic [2:0] GET_LEN        = 3'd3;
	localparam logic [2:0] POST_LEN       = 3'd4;
	localparam logic [3:0] VER_LEN_MAX    = 4'd15;
	localparam logic [3:0] VER_PREFIX_LEN = 4'd7;
	localparam logic [3:0] VER_LEN        = 4'd8;

	// Default result queue depth.
	localparam int RESULT_DEPTH = 4;

	typedef enum logic [2:0] {
		PH_METHOD = 3'd0,
		PH_PATH   = 3'd1,
		PH_VERSION = 3'd2,
		PH_HNAME  = 3'd3,
		PH_HVALUE = 3'd4,
		PH_BODY   = 3'd5
	} phase_t;

	// Parser state kept between bytes (the held return lives apart).
	typedef struct packed {
		phase_t     phase;
		logic [2:0] method_len;
		logic [1:0] cand;       // bit 0: GET still possible, bit 1: POST
		logic [3:0] ver_len;
		logic       ver_ok;
		logic       ver_zero;
		logic       line_empty;
		logic       skip;
	} st_t;

	localparam st_t ST_RESET = '{
		phase:      PH_METHOD,
		method_len: 3'd0,
		cand:       2'b11,
		ver_len:    4'd0,
		ver_ok:     1'b1,
		ver_zero:   1'b0,
		line_empty: 1'b1,
		skip:       1'b0
	};

	// One result beat.
	typedef struct packed {
		logic [7:0] data;
		logic [2:0] kind;
		logic       line_end;
		logic [1:0] method_code;
		logic       path_found;
		logic [1:0] version_code;
		logic       header_valid;
		logic       body_begins;
		logic       last;
	} res_t;

	typedef struct packed {
		st_t  st;
		res_t res;
	} step_t;

	function automatic logic [7:0] get_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = 8'h47; // G
			2'd1:    c = 8'h45; // E
			2'd2:    c = 8'h54; // T
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] post_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = 8'h50; // P
			2'd1:    c = 8'h4F; // O
			2'd2:    c = 8'h53; // S
			default: c = 8'h54; // T
		endcase
		return c;
	endfunction

	function automatic logic [7:0] ver_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h48; // H
			3'd1:    c = 8'h54; // T
			3'd2:    c = 8'h54; // T
			3'd3:    c = 8'h50; // P
			3'd4:    c = 8'h2F; // /
			3'd5:    c = 8'h31; // 1
			3'd6:    c = 8'h2E; // .
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Tag one byte and advance the parser state.
	function automatic step_t classify(input st_t st_in, input logic [7:0] b);
		step_t r;
		r = '0;
		r.st = st_in;
		r.res.data = b;
		r.res.kind = KIND_DELIM;
		case (st_in.phase)
			PH_PATH: begin
				if (b == CHAR_SP) r.st.phase = PH_VERSION;
				else r.res.kind = KIND_PATH;
			end
			PH_VERSION: begin
				r.res.kind = KIND_VER;
				if (st_in.ver_len < VER_PREFIX_LEN && b != ver_char(st_in.ver_len[2:0]))
					r.st.ver_ok = 1'b0;
				r.st.ver_zero = (b == CHAR_ZERO);
				if (st_in.ver_len < VER_LEN_MAX) r.st.ver_len = st_in.ver_len + 4'd1;
			end
			PH_HNAME: begin
				r.st.line_empty = 1'b0;
				if (b == CHAR_COLON) begin
					r.st.phase = PH_HVALUE;
					r.st.skip = 1'b1;
				end else begin
					r.res.kind = KIND_HNAME;
				end
			end
			PH_HVALUE: begin
				r.st.line_empty = 1'b0;
				if (st_in.skip) r.st.skip = 1'b0;
				else r.res.kind = KIND_HVALUE;
			end
			PH_BODY: begin
				r.res.kind = KIND_BODY;
			end
			default: begin
				// Method phase; unused codes fall back to it as well.
				r.st.phase = PH_METHOD;
				if (b == CHAR_SP) begin
					r.st.phase = PH_PATH;
				end else begin
					r.res.kind = KIND_METHOD;
					if (st_in.method_len >= GET_LEN || b != get_char(st_in.method_len[1:0]))
						r.st.cand[0] = 1'b0;
					if (st_in.method_len >= POST_LEN || b != post_char(st_in.method_len[1:0]))
						r.st.cand[1] = 1'b0;
					if (st_in.method_len < METHOD_LEN_MAX)
						r.st.method_len = st_in.method_len + 3'd1;
				end
			end
		endcase
		return r;
	endfunction

	// Close a line at its line feed and produce the line reports.
	function automatic step_t close_line(input st_t st_in);
		step_t r;
		r = '0;
		r.st = st_in;
		r.res.data = CHAR_LF;
		r.res.kind = KIND_DELIM;
		r.res.line_end = 1'b1;
		if (st_in.phase == PH_METHOD || st_in.phase == PH_PATH ||
		    st_in.phase == PH_VERSION) begin
			// End of the request line.
			if (st_in.phase != PH_METHOD) begin
				if (st_in.cand[0] && st_in.method_len == GET_LEN)
					r.res.method_code = METHOD_GET;
				else if (st_in.cand[1] && st_in.method_len == POST_LEN)
					r.res.method_code = METHOD_POST;
			end
			r.res.path_found = (st_in.phase == PH_VERSION);
			if (st_in.phase == PH_VERSION && st_in.ver_len == VER_LEN && st_in.ver_ok)
				r.res.version_code = st_in.ver_zero ? VER_1_0 : VER_1_1;
			r.st.phase = PH_HNAME;
		end else if (st_in.line_empty) begin
			r.res.body_begins = 1'b1;
			r.st.phase = PH_BODY;
		end else begin
			r.res.header_valid = (st_in.phase == PH_HVALUE);
			r.st.phase = PH_HNAME;
		end
		r.st.line_empty = 1'b1;
		r.st.skip = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/http_request_tokenizer.sv */
// HTTP request tokenizer top level: per-byte classification and result queue.
// Depends on hrt_pkg.
//
// Usage: request bytes enter one per beat on the input channel (in_valid,
// in_stall, data_byte, end_of_request). Each byte is tagged at the edge that
// accepts it, and its zero, one or two results go into a small result queue
// that drives the output channel (out_valid, out_stall and the result fields).
// A carriage return outside the body is held until the next byte: with a line
// feed it yields the return and the line-closing line feed (two results),
// otherwise the return comes out as an ordinary byte ahead of the new one.
// A result is written into the queue at the edge that accepts its byte.
// Throughput: one byte per cycle while in_stall is low, bounded by the output
// at one result per cycle; a CRLF pair takes two output beats. in_stall is
// raised from the registered queue count whenever fewer than two queue entries
// are free, so it does not depend on out_stall in the same cycle.
// When the receiver stalls, the head result stays on the outputs unchanged
// and the queue absorbs new results until it fills.
// Reset empties the queue, drops any held return and puts the parser at the
// start of a request line. The byte marked end_of_request ends the request.
`timescale 1ns / 1ps
`default_nettype none

module http_request_tokenizer #(
	parameter int FIFO_DEPTH = hrt_pkg::RESULT_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_request,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic [2:0]      byte_kind,
	output logic            line_end,
	output logic [1:0]      method_code,
	output logic            path_found,
	output logic [1:0]      version_code,
	output logic            header_valid,
	output logic            body_begins,
	output logic            last_of_run
);

	localparam int PTR_W = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] STALL_LVL = CNT_W'(FIFO_DEPTH - 2);

	hrt_pkg::st_t  st_q;
	logic          held_q;
	hrt_pkg::st_t  st_next;
	logic          held_next;
	hrt_pkg::res_t res0;
	hrt_pkg::res_t res1;
	logic [1:0]    push_n;

	hrt_pkg::res_t    queue_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_plus1;
	logic [PTR_W-1:0] wr_plus2;
	logic [PTR_W-1:0] rd_plus1;
	logic             accept;
	logic             pop;

	assign in_stall = (count_q > STALL_LVL);
	assign accept   = in_valid && !in_stall;
	assign out_valid = (count_q != '0);
	assign pop      = out_valid && !out_stall;

	// Per-byte work: settle a held return, then tag the new byte.
	always_comb begin
		hrt_pkg::step_t a;
		hrt_pkg::step_t c;
		hrt_pkg::st_t   s;
		logic           consumed;
		logic [1:0]     n;
		res0      = '0;
		res1      = '0;
		s         = st_q;
		held_next = 1'b0;
		consumed  = 1'b0;
		n         = 2'd0;
		a         = '0;
		c         = '0;
		if (held_q) begin
			if (data_byte == hrt_pkg::CHAR_LF && st_q.phase != hrt_pkg::PH_BODY) begin
				res0.data = hrt_pkg::CHAR_CR;
				res0.kind = hrt_pkg::KIND_DELIM;
				a = hrt_pkg::close_line(st_q);
				res1 = a.res;
				s = a.st;
				n = 2'd2;
				consumed = 1'b1;
			end else begin
				a = hrt_pkg::classify(st_q, hrt_pkg::CHAR_CR);
				res0 = a.res;
				s = a.st;
				n = 2'd1;
			end
		end
		if (!consumed) begin
			if (data_byte == hrt_pkg::CHAR_CR && s.phase != hrt_pkg::PH_BODY &&
			    !end_of_request) begin
				held_next = 1'b1;
			end else begin
				c = hrt_pkg::classify(s, data_byte);
				s = c.st;
				if (n == 2'd0) res0 = c.res;
				else res1 = c.res;
				n = n + 2'd1;
			end
		end
		// Mark the final result of this byte.
		if (n == 2'd1) res0.last = 1'b1;
		if (n == 2'd2) res1.last = 1'b1;
		if (end_of_request) begin
			s = hrt_pkg::ST_RESET;
			held_next = 1'b0;
		end
		st_next = s;
		push_n  = accept ? n : 2'd0;
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= hrt_pkg::ST_RESET;
			held_q <= 1'b0;
		end else if (accept) begin
			st_q   <= st_next;
			held_q <= held_next;
		end
	end

	// Queue pointer arithmetic with wrap at the depth.
	assign wr_plus1 = (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
	assign wr_plus2 = (wr_plus1 == PTR_LAST) ? '0 : wr_plus1 + 1'b1;
	assign rd_plus1 = (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) queue_q[wr_q] <= res0;
		if (push_n == 2'd2) queue_q[wr_plus1] <= res1;
	end

	// Result queue control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			case (push_n)
				2'd1:    wr_q <= wr_plus1;
				2'd2:    wr_q <= wr_plus2;
				default: wr_q <= wr_q;
			endcase
			if (pop) rd_q <= rd_plus1;
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	// Head of the queue drives the output beat.
	always_comb begin
		hrt_pkg::res_t h;
		h            = queue_q[rd_q];
		out_byte     = h.data;
		byte_kind    = h.kind;
		line_end     = h.line_end;
		method_code  = h.method_code;
		path_found   = h.path_found;
		version_code = h.version_code;
		header_valid = h.header_valid;
		body_begins  = h.body_begins;
		last_of_run  = h.last;
	end

endmodule

`default_nettype wire

/* design/hrt_checker.sv */
// Port-level checks for the HTTP request tokenizer, bound to the top level.
// Depends on hrt_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module hrt_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic [2:0] byte_kind,
	input wire logic       line_end,
	input wire logic [1:0] method_code,
	input wire logic       path_found,
	input wire logic [1:0] version_code,
	input wire logic       header_valid,
	input wire logic       body_begins,
	input wire logic       last_of_run
);

	// A stalled output beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_of_run))
		else $error("output beat changed while stalled");

	// Line reports appear only on a line-closing beat.
	a_reports_at_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_end |-> method_code == hrt_pkg::METHOD_OTHER && !path_found &&
			version_code == hrt_pkg::VER_INVALID && !header_valid && !body_begins)
		else $error("line report outside a line end");

	// A line end is the delimiting line feed.
	a_line_end_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_end |-> out_byte == hrt_pkg::CHAR_LF &&
			byte_kind == hrt_pkg::KIND_DELIM)
		else $error("line end on a byte other than a delimiting line feed");

	// The line feed that closes a line is always the last result of its byte.
	a_line_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_end |-> last_of_run)
		else $error("line end not marked as last of run");

endmodule

bind http_request_tokenizer hrt_checker u_hrt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.out_byte     (out_byte),
	.byte_kind    (byte_kind),
	.line_end     (line_end),
	.method_code  (method_code),
	.path_found   (path_found),
	.version_code (version_code),
	.header_valid (header_valid),
	.body_begins  (body_begins),
	.last_of_run  (last_of_run)
);

`default_nettype wire
